>>> hw/rtl/lcg48_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lcg48_pkg - shared constants of the 48-bit LCG random generator
// Holds the generator constants, field widths and request mode codes.
// ============================================================================
package lcg48_pkg;

    localparam int STATE_W   = 48;
    localparam int MULT_W    = 35;
    localparam int VALUE_W   = 53;
    localparam int DRAW_W    = 31;

    localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'hB;

    localparam logic [2:0] MODE_RESEED = 3'd0;
    localparam logic [2:0] MODE_BITS   = 3'd1;
    localparam logic [2:0] MODE_BOUND  = 3'd2;
    localparam logic [2:0] MODE_BOOL   = 3'd3;
    localparam logic [2:0] MODE_FLOAT  = 3'd4;
    localparam logic [2:0] MODE_DOUBLE = 3'd5;

endpackage : lcg48_pkg
`default_nettype wire

>>> hw/rtl/lcg48_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lcg48_step - serial LCG state advance
// Computes state * multiplier + increment mod 2^48, one multiplier bit a cycle.
// ============================================================================
module lcg48_step
    import lcg48_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [STATE_W-1:0] state_in,
    output logic                    done,
    output logic      [STATE_W-1:0] state_out
);

    localparam logic [5:0] LAST_BIT = 6'(MULT_W - 1);

    logic               run_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [STATE_W-1:0] acc_reg;
    logic [STATE_W-1:0] mcand_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: add the shifted multiplicand where the constant has a one
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg   <= LCG_ADD;
            mcand_reg <= state_in;
        end
        else if (run_reg)
        begin
            if (LCG_MULT[cnt_reg])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg <= {mcand_reg[STATE_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign state_out = acc_reg;

endmodule : lcg48_step
`default_nettype wire

>>> hw/rtl/lcg48_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lcg48_rem - serial 31-bit remainder
// Restoring division, one dividend bit a cycle; gives the remainder only.
// ============================================================================
module lcg48_rem
    import lcg48_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [DRAW_W-1:0] dividend,
    input  wire logic [DRAW_W-1:0] divisor,
    output logic                   done,
    output logic      [DRAW_W-1:0] remainder
);

    localparam logic [4:0] LAST_BIT = 5'(DRAW_W - 1);

    logic              run_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DRAW_W-1:0] dvd_reg;
    logic [DRAW_W-1:0] dsr_reg;
    logic [DRAW_W-1:0] rem_reg;
    logic [DRAW_W:0]   trial;
    logic [DRAW_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[DRAW_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // keep the trial remainder below the divisor
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DRAW_W-2:0], 1'b0};
            if (!diff[DRAW_W])
                rem_reg <= diff[DRAW_W-1:0];
            else
                rem_reg <= trial[DRAW_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule : lcg48_rem
`default_nettype wire

>>> hw/rtl/lcg48_random_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lcg48_random_generator_unit - 48-bit LCG random generator with request port
// Reseeds or draws raw bits, bounded integers, booleans and fixed-point
// fractions from a 48-bit linear congruential state.
// ============================================================================
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   mode selects the work; seed_value, bit_count and bound are read at that
//   edge only. A result beat is shown on value and bound_clamped for one
//   cycle with done high; the receiver takes it and cannot hold it off.
// Sequence:
//   Each state advance runs through a bit-serial multiplier that consumes one
//   multiplier bit a cycle.
//   Reseed and unused modes 6 and 7 give no result.
//   Raw bits, boolean, float: one advance, then done.
//   Double fraction: two advances, then done.
//   Bounded int, power-of-two bound: one advance, then right shifts of the
//   draw until the bound reaches bit 31. Other bounds: one advance plus a
//   serial remainder; each rejected draw repeats both.
//   busy stays high for the whole request; one request at a time.
// Reset: the state is cleared to zero, no request is pending.
// ============================================================================
module lcg48_random_generator_unit
    import lcg48_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] seed_value,
    input  wire logic [5:0]         bit_count,
    input  wire logic signed [31:0] bound,
    output logic                    done,
    output logic      [VALUE_W-1:0] value,
    output logic                    bound_clamped
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0]         fsm_reg;
    logic [1:0]         fsm_next;
    logic [STATE_W-1:0] lcg_state_reg;
    logic [2:0]         mode_reg;
    logic [5:0]         bc_reg;
    logic [DRAW_W-1:0]  bnd_reg;
    logic               clamp_reg;
    logic               second_reg;
    logic [25:0]        hi_reg;
    logic [DRAW_W-1:0]  r_reg;
    logic [31:0]        tmp_reg;
    logic               done_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               bound_clamped_reg;

    logic               accept;
    logic               mul_go;
    logic               mul_done;
    logic [STATE_W-1:0] mul_out;
    logic [STATE_W-1:0] step_seed;
    logic               rem_go;
    logic               rem_done;
    logic [DRAW_W-1:0]  rem_out;
    logic [DRAW_W-1:0]  draw;
    logic               bnd_pow2;
    logic [32:0]        limit;
    logic               draw_ok;
    logic               bnd_bad;
    logic [5:0]         bc_sat;
    logic [31:0]        raw_bits;

    assign accept = start && !busy;
    assign busy   = (fsm_reg != S_IDLE);

    assign draw     = mul_out[STATE_W-1 -: DRAW_W];
    assign bnd_pow2 = ((bnd_reg & (bnd_reg - DRAW_W'(1))) == '0);
    // a draw is kept unless its bucket runs past the 31-bit range
    assign limit    = {2'b00, r_reg} - {2'b00, rem_out} + {2'b00, bnd_reg} - 33'd1;
    assign draw_ok  = (limit[32:31] == 2'b00);
    assign bnd_bad  = (bound == 32'sd0) || bound[31];
    assign bc_sat   = (bit_count > 6'd32) ? 6'd32 : bit_count;
    // top bit_count bits of the fresh state; a zero count shifts them all out
    assign raw_bits = mul_out[STATE_W-1 -: 32] >> (6'd32 - bc_reg);

    // chain the second advance of a double straight from the multiplier,
    // before the state register has taken the first result
    assign step_seed = mul_done ? mul_out : lcg_state_reg;

    // start an advance on a drawing request, on the second half of a double,
    // and on a rejected bounded draw
    always_comb
    begin
        mul_go = 1'b0;
        if (accept && (mode != MODE_RESEED) && (mode <= MODE_DOUBLE))
            mul_go = 1'b1;
        if ((fsm_reg == S_STEP) && mul_done && (mode_reg == MODE_DOUBLE) && !second_reg)
            mul_go = 1'b1;
        if ((fsm_reg == S_DIV) && rem_done && !draw_ok)
            mul_go = 1'b1;
    end

    assign rem_go = (fsm_reg == S_STEP) && mul_done && (mode_reg == MODE_BOUND) && !bnd_pow2;

    lcg48_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mul_go),
        .state_in  (step_seed),
        .done      (mul_done),
        .state_out (mul_out)
    );

    lcg48_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (rem_go),
        .dividend  (draw),
        .divisor   (bnd_reg),
        .done      (rem_done),
        .remainder (rem_out)
    );

    // sequencer
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (mul_go)
                    fsm_next = S_STEP;
            end
            S_STEP:
            begin
                if (mul_done)
                begin
                    case (mode_reg)
                        MODE_DOUBLE:
                        begin
                            if (second_reg)
                                fsm_next = S_IDLE;
                        end
                        MODE_BOUND:
                        begin
                            fsm_next = bnd_pow2 ? S_SHIFT : S_DIV;
                        end
                        default:
                        begin
                            fsm_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (tmp_reg[31])
                    fsm_next = S_IDLE;
            end
            S_DIV:
            begin
                if (rem_done)
                    fsm_next = draw_ok ? S_IDLE : S_STEP;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            lcg_state_reg <= '0;
            done_reg      <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            done_reg <= 1'b0;
            if (accept && (mode == MODE_RESEED))
                lcg_state_reg <= {{16{seed_value[31]}}, seed_value}
                                 ^ {{(STATE_W-MULT_W){1'b0}}, LCG_MULT};
            else if (mul_done)
                lcg_state_reg <= mul_out;
            if (accept)
                second_reg <= 1'b0;
            else if ((fsm_reg == S_STEP) && mul_done && (mode_reg == MODE_DOUBLE))
                second_reg <= 1'b1;
            if ((fsm_reg == S_STEP) && mul_done && (mode_reg != MODE_BOUND)
                && ((mode_reg != MODE_DOUBLE) || second_reg))
                done_reg <= 1'b1;
            if ((fsm_reg == S_SHIFT) && tmp_reg[31])
                done_reg <= 1'b1;
            if ((fsm_reg == S_DIV) && rem_done && draw_ok)
                done_reg <= 1'b1;
        end
    end

    // request fields and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            bc_reg    <= bc_sat;
            bnd_reg   <= bnd_bad ? DRAW_W'(1) : bound[DRAW_W-1:0];
            clamp_reg <= bnd_bad;
        end
        if ((fsm_reg == S_STEP) && mul_done)
        begin
            hi_reg  <= mul_out[STATE_W-1 -: 26];
            r_reg   <= draw;
            tmp_reg <= {1'b0, bnd_reg};
            case (mode_reg)
                MODE_BITS:
                begin
                    value_reg <= {21'd0, raw_bits};
                end
                MODE_BOOL:
                begin
                    value_reg <= {52'd0, mul_out[STATE_W-1]};
                end
                MODE_FLOAT:
                begin
                    value_reg <= {29'd0, mul_out[STATE_W-1 -: 24]};
                end
                MODE_DOUBLE:
                begin
                    value_reg <= {hi_reg, mul_out[STATE_W-1 -: 27]};
                end
                default:
                begin
                    value_reg <= value_reg;
                end
            endcase
            bound_clamped_reg <= 1'b0;
        end
        // power-of-two bound: drop one low bit per cycle until the bound
        // reaches bit 31, which equals the multiply and shift
        if (fsm_reg == S_SHIFT)
        begin
            if (tmp_reg[31])
            begin
                value_reg         <= {22'd0, r_reg};
                bound_clamped_reg <= clamp_reg;
            end
            else
            begin
                r_reg   <= {1'b0, r_reg[DRAW_W-1:1]};
                tmp_reg <= {tmp_reg[30:0], 1'b0};
            end
        end
        if ((fsm_reg == S_DIV) && rem_done)
        begin
            value_reg         <= {22'd0, rem_out};
            bound_clamped_reg <= clamp_reg;
        end
    end

    assign done          = done_reg;
    assign value         = value_reg;
    assign bound_clamped = bound_clamped_reg;

endmodule : lcg48_random_generator_unit
`default_nettype wire
